@@ rtl/core/escaped_frame_encoder_unit_assert.svh @@
// Assertion macros used by the checker file of the frame encoder.
`ifndef ESCAPED_FRAME_ENCODER_UNIT_ASSERT_SVH
`define ESCAPED_FRAME_ENCODER_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define EFE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define EFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/efe_pkg.sv @@
`default_nettype none
package efe_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'hF0;
    localparam logic [7:0] ESC_BYTE  = 8'hF1;
    localparam logic [7:0] ESC_OF_F1 = 8'h01;
    localparam logic [7:0] ESC_OF_F0 = 8'h02;

    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // A header with an empty payload expands to the most byte slots:
    // flag, four header bytes, checksum, closing flag.
    localparam int SLOTS    = 7;
    localparam int SLOT_W   = 3;
    localparam int LEN_W    = 13;
    localparam int CMD_W    = 16;

    // One unit of work for the back end: a list of unescaped byte slots.
    typedef struct packed {
        logic [SLOTS-1:0][7:0] bytes;     // slot values, slot 0 first on the wire
        logic [SLOTS-1:0]      lit;       // 1: send as is, 0: escape if needed
        logic [SLOT_W-1:0]     last_slot; // index of the final slot
        logic                  done;      // final slot closes the frame
    } t_job;

endpackage
`default_nettype wire

@@ rtl/core/efe_front.sv @@
`default_nettype none
// Front end: keeps the frame state and turns each request into a job.
module efe_front #(
    parameter int MAX_PAYLOAD = 4096
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_wdata,
    input  wire logic                       i_accept,
    input  wire logic                       i_op,
    input  wire logic [efe_pkg::CMD_W-1:0]  i_command,
    input  wire logic [efe_pkg::LEN_W-1:0]  i_length,
    input  wire logic [7:0]                 i_data,
    output efe_pkg::t_job                   o_job,
    output logic                            o_push
);

    logic                      r_peer_ready;
    logic                      r_in_frame, n_in_frame;
    logic                      r_dropping, n_dropping;
    logic [efe_pkg::LEN_W-1:0] r_left,     n_left;
    logic [7:0]                r_xor,      n_xor;

    logic [efe_pkg::LEN_W-1:0] left_dec;
    logic [7:0]                hdr_xor;
    logic [7:0]                pay_xor;
    logic                      too_long;

    assign hdr_xor  = i_command[15:8] ^ i_command[7:0]
                    ^ {3'b000, i_length[12:8]} ^ i_length[7:0];
    assign pay_xor  = r_xor ^ i_data;
    assign left_dec = r_left - efe_pkg::LEN_W'(1);
    assign too_long = {4'b0000, i_length} > 17'(MAX_PAYLOAD);

    always_comb begin
        n_in_frame = r_in_frame;
        n_dropping = r_dropping;
        n_left     = r_left;
        n_xor      = r_xor;
        o_push     = 1'b0;
        o_job      = '0;
        if (i_accept) begin
            if (i_op == efe_pkg::OP_HEADER) begin
                n_left     = i_length;
                n_in_frame = (i_length != '0);
                if (!r_peer_ready || too_long) begin
                    n_dropping = (i_length != '0);
                    n_xor      = '0;
                end else begin
                    n_dropping   = 1'b0;
                    n_xor        = hdr_xor;
                    o_push       = 1'b1;
                    o_job.bytes[0] = efe_pkg::FLAG_BYTE;
                    o_job.lit[0]   = 1'b1;
                    o_job.bytes[1] = i_command[15:8];
                    o_job.bytes[2] = i_command[7:0];
                    o_job.bytes[3] = {3'b000, i_length[12:8]};
                    o_job.bytes[4] = i_length[7:0];
                    if (i_length == '0) begin
                        o_job.bytes[5]  = hdr_xor;
                        o_job.bytes[6]  = efe_pkg::FLAG_BYTE;
                        o_job.lit[6]    = 1'b1;
                        o_job.last_slot = efe_pkg::SLOT_W'(6);
                        o_job.done      = 1'b1;
                    end else begin
                        o_job.last_slot = efe_pkg::SLOT_W'(4);
                    end
                end
            end else begin
                if (!r_in_frame || r_left == '0) begin
                    n_in_frame = 1'b0;
                    n_dropping = 1'b0;
                end else begin
                    n_left = left_dec;
                    if (!r_dropping) begin
                        n_xor          = pay_xor;
                        o_push         = 1'b1;
                        o_job.bytes[0] = i_data;
                        if (left_dec == '0) begin
                            o_job.bytes[1]  = pay_xor;
                            o_job.bytes[2]  = efe_pkg::FLAG_BYTE;
                            o_job.lit[2]    = 1'b1;
                            o_job.last_slot = efe_pkg::SLOT_W'(2);
                            o_job.done      = 1'b1;
                        end
                    end
                    if (left_dec == '0) begin
                        n_in_frame = 1'b0;
                        n_dropping = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer_ready <= 1'b0;
            r_in_frame   <= 1'b0;
            r_dropping   <= 1'b0;
            r_left       <= '0;
            r_xor        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_peer_ready <= i_cfg_wdata;
            end
            r_in_frame <= n_in_frame;
            r_dropping <= n_dropping;
            r_left     <= n_left;
            r_xor      <= n_xor;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/efe_fifo.sv @@
`default_nettype none
// Two-entry job queue between the front and back ends.
module efe_fifo (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire efe_pkg::t_job i_job,
    input  wire logic    i_pop,
    output efe_pkg::t_job o_job,
    output logic         o_valid,
    output logic         o_full
);

    efe_pkg::t_job r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_job   = r_mem[r_rd_ptr];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/efe_back.sv @@
`default_nettype none
// Back end: walks the slots of the head job, escapes, and drives one wire
// byte per cycle through an output register while a job is queued and the output is not stalled.
module efe_back (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire efe_pkg::t_job i_job,
    input  wire logic    i_job_valid,
    output logic         o_pop,
    input  wire logic    i_ready,
    output logic         o_valid,
    output logic [7:0]   o_byte,
    output logic         o_done,
    output logic         o_last
);

    logic [efe_pkg::SLOT_W-1:0] r_slot;
    logic                       r_esc;
    logic                       r_valid;
    logic [7:0]                 r_byte;
    logic                       r_done;
    logic                       r_last;

    logic [7:0] cur;
    logic       needs_esc;
    logic       advance;
    logic       step_done;
    logic       slot_end;
    logic [7:0] wire_byte;

    assign cur       = i_job.bytes[r_slot];
    assign needs_esc = !i_job.lit[r_slot]
                     && (cur == efe_pkg::ESC_BYTE || cur == efe_pkg::FLAG_BYTE);
    assign advance   = i_job_valid && (!r_valid || i_ready);

    always_comb begin
        if (r_esc) begin
            wire_byte = (cur == efe_pkg::ESC_BYTE) ? efe_pkg::ESC_OF_F1 : efe_pkg::ESC_OF_F0;
            step_done = 1'b1;
        end else if (needs_esc) begin
            wire_byte = efe_pkg::ESC_BYTE;
            step_done = 1'b0;
        end else begin
            wire_byte = cur;
            step_done = 1'b1;
        end
    end

    assign slot_end = step_done && (r_slot == i_job.last_slot);
    assign o_pop    = advance && slot_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_esc   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                if (slot_end) begin
                    r_slot <= '0;
                    r_esc  <= 1'b0;
                end else if (step_done) begin
                    r_slot <= r_slot + efe_pkg::SLOT_W'(1);
                    r_esc  <= 1'b0;
                end else begin
                    r_esc  <= 1'b1;
                end
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte <= wire_byte;
            r_done <= slot_end && i_job.done;
            r_last <= slot_end;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_done  = r_done;
    assign o_last  = r_last;

endmodule
`default_nettype wire

@@ rtl/core/escaped_frame_encoder_unit.sv @@
// Channel   | Direction | Ports                                  | Carries
// ----------+-----------+----------------------------------------+---------------------------
// s_axis    | in        | i_s_tvalid, o_s_tready, i_s_tdata/user | header or payload request
// m_axis    | out       | o_m_tvalid, i_m_tready, o_m_tdata/...  | escaped wire bytes
// cfg       | in        | i_cfg_we, i_cfg_wdata                  | peer_ready register
//
// The output gives one wire byte per cycle while jobs are queued and the output is not
// stalled; after escaping, a sent header yields 5 to 9 wire bytes, a sent payload byte 1 to 5.
// A request is taken whenever the job queue is not full; a two-entry job queue lets the
// front end take new requests while the back end still drains earlier jobs.
// Dropped frames and stray bytes are absorbed with no output.
// Reset is synchronous and active low and clears all control state.
`default_nettype none
module escaped_frame_encoder_unit #(
    parameter int MAX_PAYLOAD = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,  // command[15:0], payload_length[28:16],
                                         // data_byte[36:29], zero[39:37]
    input  wire logic        i_s_tuser,  // operation
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,  // out_byte
    output logic             o_m_tlast,  // frame_done
    output logic             o_m_tuser   // last_of_run
);

    efe_pkg::t_job push_job;
    efe_pkg::t_job head_job;
    logic          push;
    logic          pop;
    logic          head_valid;
    logic          full;
    logic          accept;

    assign o_s_tready = !full;
    assign accept     = i_s_tvalid && !full;

    efe_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_op        (i_s_tuser),
        .i_command   (i_s_tdata[15:0]),
        .i_length    (i_s_tdata[28:16]),
        .i_data      (i_s_tdata[36:29]),
        .o_job       (push_job),
        .o_push      (push)
    );

    efe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_valid (head_valid),
        .o_full  (full)
    );

    efe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_valid (head_valid),
        .o_pop       (pop),
        .i_ready     (i_m_tready),
        .o_valid     (o_m_tvalid),
        .o_byte      (o_m_tdata),
        .o_done      (o_m_tlast),
        .o_last      (o_m_tuser)
    );

endmodule
`default_nettype wire

@@ rtl/core/efe_checker.sv @@
`default_nettype none
`include "escaped_frame_encoder_unit_assert.svh"
// Port-level checks of the frame encoder.
module efe_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [7:0]  o_m_tdata,
    input  wire logic        o_m_tlast,
    input  wire logic        o_m_tuser
);

    logic        out_end;
    logic        out_is_flag;
    logic        stall;
    logic [9:0]  out_word;

    assign out_end     = o_m_tvalid && o_m_tlast;
    assign out_is_flag = (o_m_tdata == efe_pkg::FLAG_BYTE);
    assign stall       = o_m_tvalid && !i_m_tready;
    assign out_word    = {o_m_tuser, o_m_tlast, o_m_tdata};

    // A closing flag always ends the run of the request that caused it.
    `EFE_ASSERT(a_done_is_last, i_clk, i_rst_n, out_end |-> o_m_tuser, "end not last of run")
    // The closing flag is never escaped.
    `EFE_ASSERT(a_done_is_flag, i_clk, i_rst_n, out_end |-> out_is_flag, "frame end not a flag")
    `EFE_ASSERT(a_hold_valid, i_clk, i_rst_n, stall |=> o_m_tvalid, "stalled valid dropped")
    `EFE_ASSERT(a_hold_data, i_clk, i_rst_n, stall |=> $stable(out_word), "stalled output changed")
    `EFE_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

endmodule

bind escaped_frame_encoder_unit efe_checker u_efe_checker (.*);
`default_nettype wire

@@ tb/escaped_frame_encoder_unit_tb.sv @@
module escaped_frame_encoder_unit_tb;

    localparam int PAYLOAD_LIMIT = 4096;

    typedef struct packed {
        logic [7:0] value;
        logic       closes;
        logic       ends_request;
    } t_wire_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // command[15:0], payload_length[28:16], data_byte[36:29], zero
    logic        i_s_tuser;   // operation
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;   // out_byte
    logic        o_m_tlast;   // frame_done
    logic        o_m_tuser;   // last_of_run

    // Shadow of the encoder state, updated as each request is accepted.
    logic        peer_ready_q = 1'b0;
    logic        frame_open   = 1'b0;
    logic        swallowing   = 1'b0;
    logic [12:0] remaining    = '0;
    logic [7:0]  checksum     = '0;

    t_wire_byte  expected_bytes[$];
    t_wire_byte  burst[$];
    int          mismatches = 0;
    logic        tx_gaps = 1'b1;
    logic        rx_gaps = 1'b1;

    escaped_frame_encoder_unit #(
        .MAX_PAYLOAD(PAYLOAD_LIMIT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tlast(o_m_tlast),
        .o_m_tuser(o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_tready <= rx_gaps ? ($urandom_range(99) >= 34) : 1'b1;
    end

    function automatic void add_raw(input logic [7:0] b, input logic closes);
        t_wire_byte w;
        w.value        = b;
        w.closes       = closes;
        w.ends_request = 1'b0;
        burst.push_back(w);
    endfunction

    function automatic void add_stuffed(input logic [7:0] b);
        if (b == efe_pkg::ESC_BYTE) begin
            add_raw(efe_pkg::ESC_BYTE, 1'b0);
            add_raw(efe_pkg::ESC_OF_F1, 1'b0);
        end else if (b == efe_pkg::FLAG_BYTE) begin
            add_raw(efe_pkg::ESC_BYTE, 1'b0);
            add_raw(efe_pkg::ESC_OF_F0, 1'b0);
        end else begin
            add_raw(b, 1'b0);
        end
    endfunction

    function automatic void add_trailer();
        add_stuffed(checksum);
        add_raw(efe_pkg::FLAG_BYTE, 1'b1);
    endfunction

    // Works out the wire bytes that one accepted request produces.
    function automatic void encode_request(input logic op, input logic [15:0] cmd,
                                           input logic [12:0] len, input logic [7:0] data);
        burst.delete();
        if (op == efe_pkg::OP_HEADER) begin
            frame_open = 1'b0;
            swallowing = 1'b0;
            remaining  = '0;
            checksum   = '0;
            if (!peer_ready_q || len > PAYLOAD_LIMIT) begin
                if (len != 0) begin
                    frame_open = 1'b1;
                    swallowing = 1'b1;
                    remaining  = len;
                end
            end else begin
                checksum = cmd[15:8] ^ cmd[7:0] ^ {3'b000, len[12:8]} ^ len[7:0];
                add_raw(efe_pkg::FLAG_BYTE, 1'b0);
                add_stuffed(cmd[15:8]);
                add_stuffed(cmd[7:0]);
                add_stuffed({3'b000, len[12:8]});
                add_stuffed(len[7:0]);
                if (len == 0) begin
                    add_trailer();
                end else begin
                    frame_open = 1'b1;
                    remaining  = len;
                end
            end
        end else if (!frame_open || remaining == 0) begin
            frame_open = 1'b0;
            swallowing = 1'b0;
        end else begin
            if (!swallowing) begin
                checksum = checksum ^ data;
                add_stuffed(data);
            end
            remaining = remaining - 13'd1;
            if (remaining == 0) begin
                if (!swallowing)
                    add_trailer();
                frame_open = 1'b0;
                swallowing = 1'b0;
            end
        end
        if (burst.size() > 0)
            burst[burst.size()-1].ends_request = 1'b1;
        foreach (burst[i])
            expected_bytes.push_back(burst[i]);
    endfunction

    // Valid is left high on return so that back-to-back requests need no idle
    // gap; the next call lowers it only for a random gap, and settle() lowers it.
    task automatic send_request(input logic op, input logic [15:0] cmd,
                                input logic [12:0] len, input logic [7:0] data);
        while (tx_gaps && $urandom_range(99) < 34) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {3'b000, data, len, cmd};
        do @(posedge i_clk); while (!o_s_tready);
        encode_request(op, cmd, len, data);
    endtask

    task automatic send_header(input logic [15:0] cmd, input int len);
        send_request(efe_pkg::OP_HEADER, cmd, 13'(len), 8'($urandom));
    endtask

    task automatic send_payload(input logic [7:0] data);
        send_request(efe_pkg::OP_PAYLOAD, 16'($urandom), 13'($urandom), data);
    endtask

    task automatic settle(input int tail);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_peer_ready(input logic ready);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ready;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        peer_ready_q = ready;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return efe_pkg::FLAG_BYTE;
            1: return efe_pkg::ESC_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly complete frames with random content; some stray bytes, some
    // frames cut short by the next header, and a few oversized headers.
    task automatic random_frames(input int count);
        int sent;
        int len;
        int body;
        int pick;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 6) begin
                send_payload(pick_byte());
                sent++;
            end else begin
                pick = $urandom_range(99);
                if (pick < 15)
                    len = 0;
                else if (pick < 85)
                    len = $urandom_range(1, 8);
                else if (pick < 95)
                    len = $urandom_range(9, 30);
                else
                    len = $urandom_range(PAYLOAD_LIMIT + 1, 8191);
                body = len;
                if (len > 30 || $urandom_range(99) < 10)
                    body = $urandom_range(0, 3);
                send_header({pick_byte(), pick_byte()}, len);
                sent++;
                for (int i = 0; i < body; i++) begin
                    send_payload(pick_byte());
                    sent++;
                end
            end
        end
    endtask

    task automatic test_peer_down();
        send_header(16'h1234, 3);
        send_payload(8'hA5);
        send_payload(8'hF0);
        send_payload(8'h5A);
        send_header(16'hABCD, 0);
        send_payload(8'h77);
        settle(20);
    endtask

    task automatic test_zero_length_and_escapes();
        write_peer_ready(1'b1);
        send_header(16'h0000, 0);
        send_header(16'hFFFF, 0);
        // The checksum of this frame is itself a flag byte.
        send_header(16'hF000, 0);
        send_header(16'hF1F0, 2);
        send_payload(efe_pkg::ESC_BYTE);
        send_payload(efe_pkg::FLAG_BYTE);
        send_payload(8'h33);
        settle(20);
    endtask

    task automatic test_oversize_and_abandon();
        send_header(16'h0102, 8191);
        send_payload(8'h11);
        send_header(16'h5555, PAYLOAD_LIMIT);
        send_payload(efe_pkg::ESC_BYTE);
        send_payload(8'h00);
        send_header(16'h00FF, PAYLOAD_LIMIT + 1);
        send_payload(8'h44);
        send_header(16'h7E7E, 1);
        send_payload(8'hFF);
        settle(20);
    endtask

    // The register only takes effect at the next header.
    task automatic test_peer_change_mid_frame();
        send_header(16'h0A0B, 2);
        send_payload(8'h01);
        settle(20);
        write_peer_ready(1'b0);
        send_payload(8'h02);
        send_header(16'h0E0F, 2);
        send_payload(8'h03);
        settle(20);
        write_peer_ready(1'b1);
        send_payload(8'h04);
        settle(20);
    endtask

    task automatic test_random_peer_up();
        random_frames(45);
        settle(20);
    endtask

    task automatic test_random_peer_down();
        write_peer_ready(1'b0);
        random_frames(10);
        settle(20);
        write_peer_ready(1'b1);
    endtask

    task automatic test_random_back_to_back();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        random_frames(30);
        settle(20);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        random_frames(30);
    endtask

    always @(posedge i_clk) begin : check_wire
        t_wire_byte want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: expected no byte, got %h (tlast %b, tuser %b)",
                         $time, o_m_tdata, o_m_tlast, o_m_tuser);
                mismatches++;
            end else begin
                want = expected_bytes.pop_front();
                if (o_m_tdata !== want.value) begin
                    $display("%0t: out_byte expected %h, got %h",
                             $time, want.value, o_m_tdata);
                    mismatches++;
                end
                if (o_m_tlast !== want.closes) begin
                    $display("%0t: frame_done expected %b, got %b",
                             $time, want.closes, o_m_tlast);
                    mismatches++;
                end
                if (o_m_tuser !== want.ends_request) begin
                    $display("%0t: last_of_run expected %b, got %b",
                             $time, want.ends_request, o_m_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = efe_pkg::OP_HEADER;
        i_m_tready  = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_peer_down();
        test_zero_length_and_escapes();
        test_oversize_and_abandon();
        test_peer_change_mid_frame();
        test_random_peer_up();
        test_random_peer_down();
        test_random_back_to_back();
        settle(30);

        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
